@@ src/rtpa_pkg.sv @@
package rtpa_pkg;

  // Fixed widths of the item fields.
  localparam int FIELD_W     = 52;
  localparam int PAGE_CNT_W  = 20;
  localparam int IDX_FIELD_W = 4;
  localparam int COUNT_W     = 5;

  // Configuration port.
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_REGION_COUNT = 1'b0;

  // Command codes of an input item.
  typedef enum logic [1:0] {
    CMD_LOAD      = 2'd0,
    CMD_ALLOC_TOP = 2'd1,
    CMD_ALLOC_LOW = 2'd2,
    CMD_CUT       = 2'd3
  } cmd_e;

  // Operations of the shared adder.
  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_EVAL   = 2'd1,
    ST_UPDATE = 2'd2,
    ST_RESP   = 2'd3
  } state_e;

  typedef struct packed {
    cmd_e                     command;
    logic [IDX_FIELD_W-1:0]   entry_index;
    logic [FIELD_W-1:0]       entry_base;
    logic [FIELD_W-1:0]       entry_length;
    logic                     entry_available;
    logic [PAGE_CNT_W-1:0]    page_count;
    logic [FIELD_W-1:0]       byte_size;
    logic [FIELD_W-1:0]       range_start;
    logic [FIELD_W-1:0]       range_end;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_W-1:0] alloc_address;
    logic               alloc_ok;
  } out_item_t;

endpackage

@@ src/rtpa_if.sv @@
// Command channel into the allocator.
interface rtpa_in_if;
  logic               valid;
  logic               ready;
  rtpa_pkg::in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

// Result channel out of the allocator.
interface rtpa_out_if;
  logic                valid;
  logic                ready;
  rtpa_pkg::out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

@@ src/rtpa_alu.sv @@
// Shared adder/subtractor. The top result bit is the carry of an add or the
// borrow of a subtract.
module rtpa_alu #(
  parameter int UW = 53
) (
  input  rtpa_pkg::alu_op_e op_i,
  input  logic [UW-1:0]     a_i,
  input  logic [UW-1:0]     b_i,
  output logic [UW:0]       res_o
);
  import rtpa_pkg::*;

  always_comb begin
    unique case (op_i)
      ALU_ADD: res_o = {1'b0, a_i} + {1'b0, b_i};
      ALU_SUB: res_o = {1'b0, a_i} - {1'b0, b_i};
      default: res_o = '0;
    endcase
  end

endmodule

@@ src/region_table_page_allocator.sv @@
// Channel   Dir  Handshake        Payload
// in_i      in   valid/ready      command, entry fields, page_count, byte_size, range
// out_o     out  valid/ready      alloc_address, alloc_ok
// APB       in   psel/penable     region_count at byte address 0
//
// A load is written when it is accepted; its result is shown in the next cycle.
// An allocation or cut visits the table entries one by one, each in a compare step
// and then an update step, since both steps go through one shared adder.
// The input is ready only when idle; a result waits in the output register.
// Reset clears the sequencer and region_count; the region table is not cleared.
module region_table_page_allocator #(
  parameter int MAX_REGIONS = 16,
  parameter int PAGE_SHIFT  = 12,
  parameter int ADDR_BITS   = 52
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  rtpa_in_if.sink                             in_i,
  rtpa_out_if.source                          out_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rtpa_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [rtpa_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [rtpa_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);
  import rtpa_pkg::*;

  localparam int DW     = (ADDR_BITS > FIELD_W) ? ADDR_BITS : FIELD_W;
  localparam int UW     = DW + 1;
  localparam int IDX_W  = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int NCNT_W = $clog2(MAX_REGIONS + 1);
  localparam int CMP_W  = (NCNT_W > COUNT_W) ? NCNT_W : COUNT_W;
  localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_REGIONS);
  localparam int REG_SEL_W = APB_ADDR_W - 2;

  // Region table.
  logic [ADDR_BITS-1:0] mem_base [MAX_REGIONS];
  logic [ADDR_BITS-1:0] mem_len  [MAX_REGIONS];
  logic                 mem_free [MAX_REGIONS];

  state_e               state_q, state_d;
  logic [COUNT_W-1:0]   count_q;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic [IDX_W-1:0]     last_q, last_d;
  cmd_e                 cmd_q;
  logic [UW-1:0]        size_q, start_q, end_q, diff_q;
  logic                 flag_q;
  logic [ADDR_BITS-1:0] rd_base_q, rd_len_q;
  logic                 rd_free_q;
  logic [FIELD_W-1:0]   out_addr_q, out_addr_d;
  logic                 out_ok_q, out_ok_d;

  logic                 accept;
  logic [CMP_W-1:0]     count_ext, n_ext;
  logic                 we;
  logic [IDX_W-1:0]     wr_addr;
  logic [ADDR_BITS-1:0] wr_base, wr_len;
  logic                 wr_free;
  alu_op_e              alu_op;
  logic [UW-1:0]        alu_a, alu_b;
  logic [UW:0]          alu_res;
  logic                 hit, last_step, is_cut, is_top;

  rtpa_alu #(.UW(UW)) u_alu (
    .op_i  (alu_op),
    .a_i   (alu_a),
    .b_i   (alu_b),
    .res_o (alu_res)
  );

  assign accept       = in_i.valid && in_i.ready;
  assign in_i.ready   = (state_q == ST_IDLE);
  assign out_o.valid  = (state_q == ST_RESP);
  assign out_o.item.alloc_address = out_addr_q;
  assign out_o.item.alloc_ok      = out_ok_q;

  // Number of valid entries, capped at the table depth.
  assign count_ext = CMP_W'(count_q);
  assign n_ext     = (count_ext > MAX_CMP) ? MAX_CMP : count_ext;

  assign is_cut    = (cmd_q == CMD_CUT);
  assign is_top    = (cmd_q == CMD_ALLOC_TOP);
  assign last_step = is_top ? (idx_q == '0) : (idx_q == last_q);

  // Configuration register.
  assign pready = 1'b1;
  assign prdata = (paddr[APB_ADDR_W-1:2] == REG_SEL_W'(REG_REGION_COUNT))
                  ? APB_DATA_W'(count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (psel && penable && pwrite &&
                 (paddr[APB_ADDR_W-1:2] == REG_SEL_W'(REG_REGION_COUNT))) begin
      count_q <= pwdata[COUNT_W-1:0];
    end
  end

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    last_d     = last_q;
    out_addr_d = out_addr_q;
    out_ok_d   = out_ok_q;
    we         = 1'b0;
    wr_addr    = idx_q;
    wr_base    = rd_base_q;
    wr_len     = rd_len_q;
    wr_free    = rd_free_q;
    alu_op     = ALU_ADD;
    alu_a      = UW'(rd_base_q);
    alu_b      = size_q;
    hit        = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          out_addr_d = '0;
          out_ok_d   = 1'b0;
          last_d     = IDX_W'(n_ext - CMP_W'(1));
          state_d    = ST_RESP;
          unique case (in_i.item.command)
            CMD_LOAD: begin
              wr_addr = IDX_W'(in_i.item.entry_index);
              wr_base = ADDR_BITS'(in_i.item.entry_base);
              wr_len  = ADDR_BITS'(in_i.item.entry_length);
              wr_free = in_i.item.entry_available;
              we      = (CMP_W'(in_i.item.entry_index) < MAX_CMP);
            end
            CMD_ALLOC_TOP: begin
              if (n_ext != '0) begin
                idx_d   = IDX_W'(n_ext - CMP_W'(1));
                state_d = ST_EVAL;
              end
            end
            CMD_ALLOC_LOW: begin
              if (n_ext != '0) begin
                idx_d   = '0;
                state_d = ST_EVAL;
              end
            end
            CMD_CUT: begin
              if (n_ext != '0 && in_i.item.range_end >= in_i.item.range_start) begin
                idx_d   = '0;
                state_d = ST_EVAL;
              end
            end
            default: state_d = ST_RESP;
          endcase
        end
      end

      // First pass of the entry: fit test for allocation, base plus length for cut.
      ST_EVAL: begin
        if (is_cut) begin
          alu_op = ALU_ADD;
          alu_a  = UW'(rd_base_q);
          alu_b  = UW'(rd_len_q);
        end else begin
          alu_op = ALU_SUB;
          alu_a  = UW'(rd_len_q);
          alu_b  = size_q;
        end
        state_d = ST_UPDATE;
      end

      // Second pass: write back the trimmed or bumped entry on a hit, then move on or respond.
      ST_UPDATE: begin
        if (is_cut) begin
          alu_op  = ALU_SUB;
          alu_a   = diff_q;
          alu_b   = end_q;
          hit     = flag_q && !alu_res[UW];
          wr_base = end_q[ADDR_BITS-1:0];
          wr_len  = alu_res[ADDR_BITS-1:0];
        end else begin
          alu_op  = ALU_ADD;
          alu_a   = UW'(rd_base_q);
          alu_b   = size_q;
          hit     = flag_q;
          wr_base = alu_res[ADDR_BITS-1:0];
          wr_len  = diff_q[ADDR_BITS-1:0];
          if (hit) begin
            out_addr_d = FIELD_W'(rd_base_q);
            out_ok_d   = 1'b1;
          end
        end
        we = hit;
        if ((hit && !is_cut) || last_step) begin
          state_d = ST_RESP;
        end else begin
          idx_d   = is_top ? idx_q - IDX_W'(1) : idx_q + IDX_W'(1);
          state_d = ST_EVAL;
        end
      end

      ST_RESP: begin
        if (out_o.ready) begin
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Captured item fields and scan working registers.
  always_ff @(posedge clk_i) begin
    last_q     <= last_d;
    out_addr_q <= out_addr_d;
    out_ok_q   <= out_ok_d;
    if (accept) begin
      cmd_q   <= in_i.item.command;
      start_q <= UW'(in_i.item.range_start);
      end_q   <= UW'(in_i.item.range_end);
      if (in_i.item.command == CMD_ALLOC_TOP) begin
        size_q <= UW'(in_i.item.page_count) << PAGE_SHIFT;
      end else begin
        size_q <= UW'(in_i.item.byte_size);
      end
    end
    if (state_q == ST_EVAL) begin
      diff_q <= alu_res[UW-1:0];
      if (is_cut) begin
        flag_q <= (start_q >= UW'(rd_base_q));
      end else begin
        flag_q <= rd_free_q && (rd_base_q[PAGE_SHIFT-1:0] == '0) && !alu_res[UW];
      end
    end
  end

  // Table write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_base[wr_addr] <= wr_base;
      mem_len[wr_addr]  <= wr_len;
      mem_free[wr_addr] <= wr_free;
    end
    rd_base_q <= mem_base[idx_d];
    rd_len_q  <= mem_len[idx_d];
    rd_free_q <= mem_free[idx_d];
  end

endmodule

@@ src/rtpa_checker.sv @@
// Port-level checks on the allocator.
module rtpa_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input rtpa_pkg::out_item_t        out_item
);
  import rtpa_pkg::*;

  // A new item is never taken while a result is still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !in_ready)
    else $error("input ready while a result is pending");

  // Accepting an item makes the block busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready right after an accepted item");

  // A failed or non-allocating item reports address zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_item.alloc_ok) |-> (out_item.alloc_address == '0))
    else $error("nonzero address without ok");

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_item)))
    else $error("result changed while stalled");

endmodule

bind region_table_page_allocator rtpa_checker u_rtpa_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_i.valid),
  .in_ready  (in_i.ready),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_item  (out_o.item)
);

@@ tb/sv/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rtpa_pkg::*;

  localparam int TABLE_DEPTH = 16;
  localparam int PAGE_BITS = 12;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [APB_ADDR_W-1:0] REGION_COUNT_ADDR = APB_ADDR_W'(4 * int'(REG_REGION_COUNT));

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  rtpa_in_if  cmd_if ();
  rtpa_out_if res_if ();

  region_table_page_allocator i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (cmd_if),
    .out_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow copy of the region table and its entry count.
  logic [FIELD_W-1:0] tbl_base   [TABLE_DEPTH];
  logic [FIELD_W-1:0] tbl_length [TABLE_DEPTH];
  logic               tbl_free   [TABLE_DEPTH];
  logic [COUNT_W-1:0] tbl_count;

  out_item_t expected_grants[$];
  int        error_count = 0;
  longint    cycle_count = 0;
  bit        calm_mode = 1'b0;
  int        hold_off_req = 0;

  always #6 clk_i = ~clk_i;

  // Run limit.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [FIELD_W-1:0] rand52();
    return FIELD_W'({$urandom, $urandom});
  endfunction

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Takes size bytes from one region if it is free, page aligned and long enough.
  function automatic bit take_from_region(input int idx, input logic [FIELD_W-1:0] size,
                                          output logic [FIELD_W-1:0] addr);
    addr = '0;
    if (!tbl_free[idx]) return 1'b0;
    if (tbl_base[idx][PAGE_BITS-1:0] != '0) return 1'b0;
    if (tbl_length[idx] < size) return 1'b0;
    addr = tbl_base[idx];
    tbl_base[idx] = tbl_base[idx] + size;
    tbl_length[idx] = tbl_length[idx] - size;
    return 1'b1;
  endfunction

  // Applies one command to the shadow table and returns the expected grant.
  function automatic out_item_t predict_table_command(input in_item_t it);
    out_item_t          res;
    logic [FIELD_W-1:0] size;
    logic [FIELD_W-1:0] addr;
    logic [FIELD_W-1:0] b;
    logic [FIELD_W-1:0] l;
    int                 n;
    res = '0;
    addr = '0;
    n = (tbl_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(tbl_count);
    case (it.command)
      CMD_LOAD: begin
        tbl_base[it.entry_index] = it.entry_base;
        tbl_length[it.entry_index] = it.entry_length;
        tbl_free[it.entry_index] = it.entry_available;
      end
      CMD_ALLOC_TOP: begin
        size = FIELD_W'(it.page_count) << PAGE_BITS;
        for (int i = n - 1; i >= 0 && !res.alloc_ok; i--) begin
          res.alloc_ok = take_from_region(i, size, addr);
        end
      end
      CMD_ALLOC_LOW: begin
        size = it.byte_size;
        for (int i = 0; i < n && !res.alloc_ok; i++) begin
          res.alloc_ok = take_from_region(i, size, addr);
        end
      end
      CMD_CUT: begin
        // Every region holding the whole range, free or not, starts at its end.
        if (it.range_end >= it.range_start) begin
          for (int i = 0; i < n; i++) begin
            b = tbl_base[i];
            l = tbl_length[i];
            if (it.range_start >= b && (it.range_end - b) <= l) begin
              tbl_base[i] = it.range_end;
              tbl_length[i] = l - (it.range_end - b);
            end
          end
        end
      end
      default: ;
    endcase
    if (res.alloc_ok) res.alloc_address = addr;
    return res;
  endfunction

  // Item with every field random.
  function automatic in_item_t filler_item();
    in_item_t it;
    it.command = cmd_e'(2'($urandom));
    it.entry_index = IDX_FIELD_W'($urandom);
    it.entry_base = rand52();
    it.entry_length = rand52();
    it.entry_available = 1'($urandom);
    it.page_count = PAGE_CNT_W'($urandom);
    it.byte_size = rand52();
    it.range_start = rand52();
    it.range_end = rand52();
    return it;
  endfunction

  // Load of a plausible region: mostly free, page aligned and a few MB long.
  function automatic in_item_t random_load(input logic [IDX_FIELD_W-1:0] idx);
    in_item_t it;
    it = filler_item();
    it.command = CMD_LOAD;
    it.entry_index = idx;
    it.entry_base = rand52() & 52'h0_00FF_FFFF_F000;
    if ($urandom_range(0, 9) == 0) it.entry_base[PAGE_BITS-1:0] = PAGE_BITS'($urandom);
    it.entry_length = FIELD_W'($urandom_range(1, 2048)) << PAGE_BITS;
    if ($urandom_range(0, 19) == 0) it.entry_length = rand52();
    it.entry_available = ($urandom_range(0, 4) != 0);
    return it;
  endfunction

  // Mostly well-formed traffic with random content, the rest noise.
  function automatic in_item_t random_command();
    in_item_t           it;
    logic [FIELD_W-1:0] b;
    logic [FIELD_W-1:0] l;
    logic [FIELD_W-1:0] off;
    logic [FIELD_W-1:0] span;
    int                 r;
    int                 k;
    it = filler_item();
    r = $urandom_range(0, 99);
    if (r < 10) return it;
    if (r < 25) return random_load(IDX_FIELD_W'($urandom));
    if (r < 55) begin
      it.command = CMD_ALLOC_TOP;
      it.page_count = ($urandom_range(0, 19) == 0) ? PAGE_CNT_W'($urandom)
                                                   : PAGE_CNT_W'($urandom_range(0, 8));
    end else if (r < 85) begin
      it.command = CMD_ALLOC_LOW;
      k = $urandom_range(0, 19);
      if (k == 0) it.byte_size = rand52();
      else if (k < 4) it.byte_size = FIELD_W'($urandom_range(0, 8191));
      else it.byte_size = FIELD_W'($urandom_range(0, 64)) << PAGE_BITS;
    end else begin
      it.command = CMD_CUT;
      // Most cuts fall inside an existing region, on page boundaries.
      if ($urandom_range(0, 4) != 0) begin
        k = $urandom_range(0, TABLE_DEPTH - 1);
        b = tbl_base[k];
        l = tbl_length[k];
        off = rand52() % (l / 2 + 1);
        off[PAGE_BITS-1:0] = '0;
        span = rand52() % ((l - off) / 2 + 1);
        span[PAGE_BITS-1:0] = '0;
        it.range_start = b + off;
        it.range_end = b + off + span;
      end
    end
    return it;
  endfunction

  // Offers one item and records its expected grant once it is accepted.
  task automatic send_item(input in_item_t it);
    int gap;
    gap = calm_mode ? 0 : idle_gap();
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.item <= it;
    do @(posedge clk_i); while (!(cmd_if.valid && cmd_if.ready));
    expected_grants.push_back(predict_table_command(it));
  endtask

  task automatic stop_sending();
    cmd_if.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (expected_grants.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic send_load(input int idx, input logic [FIELD_W-1:0] base,
                           input logic [FIELD_W-1:0] length, input logic avail);
    in_item_t it;
    it = filler_item();
    it.command = CMD_LOAD;
    it.entry_index = IDX_FIELD_W'(idx);
    it.entry_base = base;
    it.entry_length = length;
    it.entry_available = avail;
    send_item(it);
  endtask

  task automatic send_top(input logic [PAGE_CNT_W-1:0] pages);
    in_item_t it;
    it = filler_item();
    it.command = CMD_ALLOC_TOP;
    it.page_count = pages;
    send_item(it);
  endtask

  task automatic send_low(input logic [FIELD_W-1:0] size);
    in_item_t it;
    it = filler_item();
    it.command = CMD_ALLOC_LOW;
    it.byte_size = size;
    send_item(it);
  endtask

  task automatic send_cut(input logic [FIELD_W-1:0] first, input logic [FIELD_W-1:0] last);
    in_item_t it;
    it = filler_item();
    it.command = CMD_CUT;
    it.range_start = first;
    it.range_end = last;
    send_item(it);
  endtask

  // Register access: setup cycle, then access cycle until pready.
  task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [APB_DATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apb_read(input logic [APB_ADDR_W-1:0] addr, output logic [APB_DATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(negedge clk_i); while (!pready);
    data = prdata;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_region_count();
    logic [APB_DATA_W-1:0] rd;
    apb_read(REGION_COUNT_ADDR, rd);
    if (rd !== APB_DATA_W'(tbl_count)) begin
      $error("region_count mismatch: expected %0d, actual %0d", tbl_count, rd);
      error_count++;
    end
  endtask

  // Only called with the block idle.
  task automatic set_region_count(input logic [COUNT_W-1:0] value);
    cmd_if.valid <= 1'b0;
    wait_drained();
    apb_write(REGION_COUNT_ADDR, APB_DATA_W'(value));
    tbl_count = value;
    @(posedge clk_i);
    check_region_count();
  endtask

  // With no valid entries nothing can be allocated or cut.
  task automatic test_empty_table();
    check_region_count();
    send_top('1);
    send_low('1);
    send_cut('0, '1);
  endtask

  // Hand-built regions covering wrap, zero sizes, misalignment and the cut cases.
  task automatic test_directed_regions();
    send_load(0, 52'hF_FFFF_FFFF_F000, 52'hF_FFFF_FFFF_FFFF, 1'b1);
    send_load(1, 52'h0_0000_0001_2345, 52'h0_0000_0010_0000, 1'b1);
    send_load(2, 52'h0, 52'h0_0000_0010_0000, 1'b0);
    send_load(3, 52'h0_0000_0010_0000, 52'h0_0000_0040_0000, 1'b1);
    set_region_count(COUNT_W'(4));
    send_top('0);
    send_top('1);
    send_low('1);
    send_low('0);
    send_low(52'h1000);
    send_low(52'h3);
    send_low(52'h1000);
    send_cut(52'h20_0000, 52'h30_0000);
    send_cut(52'h8_0000, 52'h4_0000);
    send_cut(52'h0, 52'h8_0000);
    send_top(20'd1);
    send_cut(52'h8_0000, 52'h8_0000);
  endtask

  // Fills the rest of the table, then runs at a full and an oversized count.
  task automatic test_full_table();
    for (int i = 4; i < TABLE_DEPTH - 1; i++) send_item(random_load(IDX_FIELD_W'(i)));
    send_load(TABLE_DEPTH - 1, 52'h8_0000_0000_0000, 52'h7_FFFF_FFFF_FFFF, 1'b1);
    set_region_count(COUNT_W'(TABLE_DEPTH));
    send_top(20'd1);
    send_low(52'h2000);
    repeat (4) send_item(random_command());
    set_region_count('1);
    send_top(20'd2);
    send_low(52'h1000);
    repeat (4) send_item(random_command());
  endtask

  // The receiver holds off long enough for the block to stall its input.
  task automatic test_backpressure();
    set_region_count(COUNT_W'(TABLE_DEPTH));
    calm_mode = 1'b1;
    hold_off_req = 250;
    repeat (12) send_item(random_command());
    stop_sending();
    calm_mode = 1'b0;
    wait_drained();
  endtask

  task automatic test_random_traffic();
    logic [COUNT_W-1:0] cnt;
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: cnt = COUNT_W'(TABLE_DEPTH);
        1: cnt = '1;
        2: cnt = COUNT_W'($urandom_range(1, TABLE_DEPTH - 1));
        3: cnt = COUNT_W'($urandom_range(TABLE_DEPTH + 1, 30));
        default: cnt = COUNT_W'(TABLE_DEPTH);
      endcase
      set_region_count(cnt);
      // One phase runs with no idling on either side.
      calm_mode = (p == 2);
      repeat (130) send_item(random_command());
    end
    calm_mode = 1'b0;
  endtask

  // Result receiver with random stalls and requested hold-offs.
  initial begin
    int stall_left;
    stall_left = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req > 0) begin
        stall_left = hold_off_req;
        hold_off_req = 0;
      end
      if (stall_left > 0) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else begin
        res_if.ready <= 1'b1;
        if (!calm_mode) stall_left = idle_gap();
      end
    end
  end

  // Each accepted result is matched against the oldest expected grant.
  always @(posedge clk_i) begin
    out_item_t want;
    out_item_t got;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got = res_if.item;
      if (expected_grants.size() == 0) begin
        $error("unexpected result: alloc_address %h, alloc_ok %b", got.alloc_address,
               got.alloc_ok);
        error_count++;
      end else begin
        want = expected_grants.pop_front();
        if (got.alloc_address !== want.alloc_address) begin
          $error("alloc_address mismatch: expected %h, actual %h", want.alloc_address,
                 got.alloc_address);
          error_count++;
        end
        if (got.alloc_ok !== want.alloc_ok) begin
          $error("alloc_ok mismatch: expected %b, actual %b", want.alloc_ok, got.alloc_ok);
          error_count++;
        end
      end
    end
  end

  // Reset, the tests in turn, then drain and report.
  initial begin
    rst_ni <= 1'b0;
    cmd_if.valid <= 1'b0;
    cmd_if.item <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    tbl_count = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      tbl_base[i] = '0;
      tbl_length[i] = '0;
      tbl_free[i] = 1'b0;
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_empty_table();
    test_directed_regions();
    test_full_table();
    test_backpressure();
    test_random_traffic();

    stop_sending();
    wait_drained();
    repeat (40) @(posedge clk_i);
    if (expected_grants.size() != 0) begin
      $error("%0d expected results never arrived", expected_grants.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/rtpa_pkg.sv
src/rtpa_if.sv
src/rtpa_alu.sv
src/region_table_page_allocator.sv
src/rtpa_checker.sv
tb/sv/testbench.sv
